FILE: hw/rtl/mmf_pkg.sv
`default_nettype none

package mmf_pkg;

  // Sysex chunks are cut at this many bytes, or where the position crosses a multiple of it.
  localparam int CHUNK_BYTES   = 256;
  // Width of the buffer position counter; it saturates at its all-ones value.
  localparam int POSITION_BITS = 16;

  localparam int PHASE_W = $clog2(CHUNK_BYTES);
  localparam int LEN_W   = $clog2(CHUNK_BYTES + 1);

  localparam logic [POSITION_BITS-1:0] POSITION_MAX = '1;
  localparam logic [PHASE_W-1:0]       PHASE_LAST   = PHASE_W'(CHUNK_BYTES - 1);
  localparam logic [LEN_W-1:0]         CHUNK_FULL   = LEN_W'(CHUNK_BYTES);

  localparam logic [7:0] SYSEX_OPEN  = 8'hF0;
  localparam logic [7:0] SYSEX_CLOSE = 8'hF7;
  localparam logic [7:0] DEPTH_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_SHORT        = 2'd0,
    KIND_SYSEX        = 2'd1,
    KIND_BAD_STATUS   = 2'd2,
    KIND_MISSING_DATA = 2'd3
  } mmf_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } mmf_item_t;

  typedef struct packed {
    mmf_kind_e   kind;
    logic [23:0] packed_message;
    logic [8:0]  message_length;
    logic [15:0] start_position;
  } mmf_result_t;

  // Number of data bytes that follow a status byte (0 for single-byte messages).
  function automatic logic [1:0] data_bytes_for(logic [7:0] status);
    logic [1:0] need;
    need = 2'd0;
    case (status[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: need = 2'd2;
      4'hC, 4'hD:                   need = 2'd1;
      4'hF: begin
        case (status[3:0])
          4'h1, 4'h3: need = 2'd1;
          4'h2:       need = 2'd2;
          default:    need = 2'd0;
        endcase
      end
      default: need = 2'd0;
    endcase
    return need;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/midi_message_framer.sv
// MIDI message framer.
// The input channel (in_valid_i / in_ready_o) carries one raw MIDI byte per
// transaction, with buffer_end_i set on the last byte of each buffer. The output
// channel (out_valid_o / out_ready_i) carries one framed result per transaction:
// a packed short message, a sysex chunk given as start offset and length, or an
// error report. A byte produces zero or one result.
// An accepted byte is held in the input register, framed from there, and its
// result is presented from the result register.
// Throughput: one byte per cycle while the result register can take a new
// result, set by the single framing stage between the input and result registers.
// Reset clears both registers and all framing state (sysex depth, buffer
// position, pending message, error flag); each buffer end clears that state too.
// When the receiver stalls, the result register holds its transaction and the
// input side keeps accepting until the input register also fills; bytes that
// produce no result still drain while the result register is occupied only if
// the output is taken.
`default_nettype none

module midi_message_framer
  import mmf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        buffer_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [23:0]      packed_message_o,
  output logic [8:0]       message_length_o,
  output logic [15:0]      start_position_o
);

  mmf_item_t   in_item;
  mmf_item_t   item_q;
  logic        item_valid;
  logic        advance;
  logic        can_load;
  logic        res_valid;
  mmf_result_t result;
  mmf_result_t result_q;

  assign in_item = '{data_byte: data_byte_i, buffer_end: buffer_end_i};
  assign advance = item_valid && can_load;

  mmf_input_reg u_input_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  mmf_framer_core u_framer_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  mmf_output_reg u_output_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .result_i    (result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_q)
  );

  assign kind_o           = result_q.kind;
  assign packed_message_o = result_q.packed_message;
  assign message_length_o = result_q.message_length;
  assign start_position_o = result_q.start_position;

`ifndef SYNTH
  // Error reports carry neither a message nor a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BAD_STATUS || kind_o == KIND_MISSING_DATA)
    |-> message_length_o == 9'd0 && packed_message_o == 24'h0)
    else $error("error result with nonzero length or payload");

  // A short message is one to three bytes long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SHORT
    |-> message_length_o >= 9'd1 && message_length_o <= 9'd3)
    else $error("short message length out of range");

  // A sysex chunk is never empty and never longer than a chunk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SYSEX
    |-> message_length_o != 9'd0 && 32'(message_length_o) <= CHUNK_BYTES)
    else $error("sysex chunk length out of range");

  // A byte held in the input register stays until it is framed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !advance |=> item_valid && $stable(item_q))
    else $error("input register lost a byte");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mmf_input_reg.sv
`default_nettype none

module mmf_input_reg
  import mmf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire mmf_item_t item_i,
  input  wire logic      advance_i,
  output logic           valid_o,
  output mmf_item_t      item_o
);

  logic      valid_q, valid_d;
  mmf_item_t item_q;

  // The register takes a new transaction when it is empty or drains this cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mmf_framer_core.sv
`default_nettype none

module mmf_framer_core
  import mmf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire mmf_item_t item_i,
  output logic           res_valid_o,
  output mmf_result_t    result_o
);

  logic [7:0]               depth_q, depth_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic [23:0]              assembly_q, assembly_d;
  logic [1:0]               collected_q, collected_d;
  logic [1:0]               needed_q, needed_d;
  logic [POSITION_BITS-1:0] chunk_start_q, chunk_start_d;
  logic [LEN_W-1:0]         chunk_len_q, chunk_len_d;
  logic                     aborted_q, aborted_d;

  logic [7:0]               b;
  logic                     last;
  logic [1:0]               collected_inc;
  logic [23:0]              assembly_add;
  logic [POSITION_BITS-1:0] span_start;
  logic [LEN_W-1:0]         len_inc;
  logic                     boundary;
  logic [1:0]               need;

  assign b    = item_i.data_byte;
  assign last = item_i.buffer_end;

  assign collected_inc = collected_q + 2'd1;
  assign assembly_add  = (collected_q == 2'd0) ? {8'h00, b, 8'h00} : {b, 16'h0000};
  assign span_start    = (chunk_len_q == '0) ? pos_q : chunk_start_q;
  assign len_inc       = chunk_len_q + LEN_W'(1);
  assign boundary      = (pos_q != POSITION_MAX) && (phase_q == PHASE_LAST);
  assign need          = data_bytes_for(b);

  // Frame one byte: pick the result and the next framing state.
  always_comb begin
    depth_d       = depth_q;
    assembly_d    = assembly_q;
    collected_d   = collected_q;
    needed_d      = needed_q;
    chunk_start_d = chunk_start_q;
    chunk_len_d   = chunk_len_q;
    aborted_d     = aborted_q;
    res_valid_o   = 1'b0;
    result_o      = '{kind: KIND_SHORT, packed_message: 24'h0, message_length: 9'h0,
                      start_position: 16'(pos_q)};

    if (aborted_q) begin
      // The rest of the buffer is skipped after an error.
    end else if (needed_q != 2'd0) begin
      // Data bytes of a pending short message, taken whatever their value.
      assembly_d  = assembly_q | assembly_add;
      collected_d = collected_inc;
      if (collected_inc >= needed_q) begin
        res_valid_o             = 1'b1;
        result_o.packed_message = assembly_q | assembly_add;
        result_o.message_length = 9'(needed_q) + 9'd1;
        result_o.start_position = 16'(chunk_start_q);
        needed_d                = 2'd0;
        collected_d             = 2'd0;
        assembly_d              = 24'h0;
      end else if (last) begin
        res_valid_o             = 1'b1;
        result_o.kind           = KIND_MISSING_DATA;
        result_o.start_position = 16'(chunk_start_q);
      end
    end else if (depth_q != 8'h00 || b == SYSEX_OPEN) begin
      // Inside a sysex span: track nesting and cut chunks.
      chunk_start_d = span_start;
      if (b == SYSEX_OPEN) begin
        if (depth_q != DEPTH_MAX) begin
          depth_d = depth_q + 8'd1;
        end
      end else if (b == SYSEX_CLOSE) begin
        depth_d = depth_q - 8'd1;
      end
      chunk_len_d = len_inc;
      if (depth_d == 8'h00 || boundary || len_inc == CHUNK_FULL || last) begin
        res_valid_o             = 1'b1;
        result_o.kind           = KIND_SYSEX;
        result_o.message_length = 9'(len_inc);
        result_o.start_position = 16'(span_start);
        chunk_len_d             = '0;
      end
    end else if (!b[7]) begin
      // Data byte where a status byte belongs.
      res_valid_o   = 1'b1;
      result_o.kind = KIND_BAD_STATUS;
      aborted_d     = 1'b1;
    end else if (need == 2'd0) begin
      res_valid_o             = 1'b1;
      result_o.packed_message = {16'h0000, b};
      result_o.message_length = 9'd1;
    end else if (last) begin
      res_valid_o   = 1'b1;
      result_o.kind = KIND_MISSING_DATA;
    end else begin
      assembly_d    = {16'h0000, b};
      needed_d      = need;
      collected_d   = 2'd0;
      chunk_start_d = pos_q;
    end

    // Position and chunk phase advance with each byte; buffer end clears everything.
    pos_d   = (pos_q == POSITION_MAX) ? pos_q : pos_q + POSITION_BITS'(1);
    phase_d = phase_q;
    if (pos_q != POSITION_MAX) begin
      phase_d = (phase_q == PHASE_LAST) ? '0 : phase_q + PHASE_W'(1);
    end
    if (last) begin
      depth_d       = 8'h00;
      pos_d         = '0;
      phase_d       = '0;
      assembly_d    = 24'h0;
      collected_d   = 2'd0;
      needed_d      = 2'd0;
      chunk_start_d = '0;
      chunk_len_d   = '0;
      aborted_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q       <= 8'h00;
      pos_q         <= '0;
      phase_q       <= '0;
      assembly_q    <= 24'h0;
      collected_q   <= 2'd0;
      needed_q      <= 2'd0;
      chunk_start_q <= '0;
      chunk_len_q   <= '0;
      aborted_q     <= 1'b0;
    end else if (advance_i) begin
      depth_q       <= depth_d;
      pos_q         <= pos_d;
      phase_q       <= phase_d;
      assembly_q    <= assembly_d;
      collected_q   <= collected_d;
      needed_q      <= needed_d;
      chunk_start_q <= chunk_start_d;
      chunk_len_q   <= chunk_len_d;
      aborted_q     <= aborted_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mmf_output_reg.sv
`default_nettype none

module mmf_output_reg
  import mmf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire mmf_result_t result_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output mmf_result_t      result_o
);

  logic        valid_q, valid_d;
  mmf_result_t result_q;

  // A new result may enter when the register is empty or being taken this cycle.
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

FILE: tb/midi_message_framer_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the MIDI framer. Every accepted input transaction
// runs through a local framing model, and every accepted output transaction is
// compared field by field with the oldest framed result still owed.
module midi_message_framer_checker
  import mmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [23:0] packed_message_i,
  input  logic [8:0]  message_length_i,
  input  logic [15:0] start_position_i,
  output int unsigned fail_count_o,
  output int unsigned frames_due_o
);

  // Keeps the log readable when the design is badly broken.
  localparam int unsigned REPORT_CAP = 100;

  // Data bytes after a status: 8x..Ex by high nibble, then F0..FF by low nibble.
  localparam logic [1:0] DATA_BYTES [23] = '{
    2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  // Framing state of the model.
  logic [7:0]               depth;
  logic [POSITION_BITS-1:0] position;
  logic [23:0]              assembly;
  logic [1:0]               collected;
  logic [1:0]               needed;
  logic [POSITION_BITS-1:0] msg_start;
  logic [LEN_W-1:0]         chunk_len;
  logic                     aborted;

  mmf_result_t framed_q[$];
  mmf_result_t head;

  initial begin
    fail_count_o = 0;
    frames_due_o = 0;
  end

  function automatic logic [1:0] data_bytes_after(input logic [7:0] status);
    int idx;
    if (status[7:4] != 4'hF) begin
      idx = int'(status[7:4]) - 8;
    end else begin
      idx = int'(status[3:0]) + 7;
    end
    return DATA_BYTES[idx];
  endfunction

  // Both reset and the end of every buffer bring the framing back to idle.
  task automatic clear_framing();
    depth     = '0;
    position  = '0;
    assembly  = '0;
    collected = '0;
    needed    = '0;
    msg_start = '0;
    chunk_len = '0;
    aborted   = 1'b0;
  endtask

  // Frames one byte and queues the result it causes, if any.
  task automatic frame_byte(input logic [7:0] b, input logic last);
    mmf_result_t res;
    logic        emit;
    logic        at_cut;
    logic [1:0]  need;
    res  = '0;
    emit = 1'b0;
    if (aborted) begin
      // After an error the rest of the buffer is dropped silently.
    end else if (needed != 2'd0) begin
      // Any byte value counts as data inside a pending short message.
      collected = collected + 2'd1;
      assembly  = assembly | (24'(b) << (8 * collected));
      if (collected >= needed) begin
        res.kind           = KIND_SHORT;
        res.packed_message = assembly;
        res.message_length = 9'(needed) + 9'd1;
        res.start_position = 16'(msg_start);
        emit      = 1'b1;
        needed    = '0;
        collected = '0;
        assembly  = '0;
      end else if (last) begin
        res.kind           = KIND_MISSING_DATA;
        res.start_position = 16'(msg_start);
        emit = 1'b1;
      end
    end else if (depth != 8'd0 || b == SYSEX_OPEN) begin
      if (chunk_len == '0) begin
        msg_start = position;
      end
      // Depth saturates; a close here always finds an open span.
      if (b == SYSEX_OPEN) begin
        if (depth != DEPTH_MAX) begin
          depth = depth + 8'd1;
        end
      end else if (b == SYSEX_CLOSE) begin
        depth = depth - 8'd1;
      end
      chunk_len = chunk_len + 1'b1;
      // Once the position saturates only the chunk length, the span end or the buffer end can cut.
      at_cut = (position != POSITION_MAX) && (position[PHASE_W-1:0] == PHASE_LAST);
      if (depth == 8'd0 || at_cut || chunk_len >= CHUNK_FULL || last) begin
        res.kind           = KIND_SYSEX;
        res.message_length = 9'(chunk_len);
        res.start_position = 16'(msg_start);
        emit      = 1'b1;
        chunk_len = '0;
      end
    end else if (!b[7]) begin
      res.kind           = KIND_BAD_STATUS;
      res.start_position = 16'(position);
      emit    = 1'b1;
      aborted = 1'b1;
    end else begin
      need = data_bytes_after(b);
      if (need == 2'd0) begin
        res.kind           = KIND_SHORT;
        res.packed_message = 24'(b);
        res.message_length = 9'd1;
        res.start_position = 16'(position);
        emit = 1'b1;
      end else if (last) begin
        res.kind           = KIND_MISSING_DATA;
        res.start_position = 16'(position);
        emit = 1'b1;
      end else begin
        assembly  = 24'(b);
        needed    = need;
        collected = '0;
        msg_start = position;
      end
    end
    if (emit) begin
      framed_q.push_back(res);
    end
    if (last) begin
      clear_framing();
    end else if (position != POSITION_MAX) begin
      position = position + 1'b1;
    end
  endtask

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (fail_count_o < REPORT_CAP) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      end
      fail_count_o++;
    end
  endfunction

  // The output transaction is checked before the input one of the same edge,
  // so a result cannot be matched against an expectation queued this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_framing();
      framed_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (framed_q.size() == 0) begin
          if (fail_count_o < REPORT_CAP) begin
            $error("result with nothing expected: kind %0d, start_position %0d",
                   kind_i, start_position_i);
          end
          fail_count_o++;
        end else begin
          head = framed_q.pop_front();
          check_field("kind", head.kind, kind_i);
          check_field("packed_message", head.packed_message, packed_message_i);
          check_field("message_length", head.message_length, message_length_i);
          check_field("start_position", head.start_position, start_position_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        frame_byte(data_byte_i, buffer_end_i);
      end
    end
    frames_due_o = framed_q.size();
  end

endmodule

FILE: tb/midi_message_framer_tb.sv
`timescale 1ns / 100ps

// Drives MIDI byte buffers into the framer and gives the verdict. Checking
// is done by the checker instance beside the design.
module midi_message_framer_tb;
  import mmf_pkg::*;

  localparam int          CLK_HALF         = 6;
  localparam int unsigned RANDOM_BYTES     = 760;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned DRAIN_CYCLES     = 8;

  // Status bytes used by the stimulus.
  localparam logic [7:0] NOTE_ON          = 8'h90;
  localparam logic [7:0] NOTE_OFF         = 8'h80;
  localparam logic [7:0] CONTROL_CHANGE   = 8'hB0;
  localparam logic [7:0] PROGRAM_CHANGE   = 8'hC0;
  localparam logic [7:0] CHANNEL_PRESSURE = 8'hD0;
  localparam logic [7:0] TIME_CODE        = 8'hF1;
  localparam logic [7:0] SONG_POSITION    = 8'hF2;
  localparam logic [7:0] SONG_SELECT      = 8'hF3;
  localparam logic [7:0] TIMING_CLOCK     = 8'hF8;
  localparam logic [7:0] SYSTEM_RESET     = 8'hFF;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte  = 8'h00;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  kind;
  logic [23:0] packed_message;
  logic [8:0]  message_length;
  logic [15:0] start_position;

  int unsigned fail_count;
  int unsigned frames_due;
  int unsigned cycles        = 0;
  int unsigned stall_left    = 0;
  logic        sender_steady = 1'b0;
  logic        drain_steady  = 1'b0;
  logic [7:0]  buffer_q[$];

  always #(CLK_HALF) clk = ~clk;

  midi_message_framer u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .buffer_end_i     (buffer_end),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .packed_message_o (packed_message),
    .message_length_o (message_length),
    .start_position_o (start_position)
  );

  midi_message_framer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_byte_i      (data_byte),
    .buffer_end_i     (buffer_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .packed_message_i (packed_message),
    .message_length_i (message_length),
    .start_position_i (start_position),
    .fail_count_o     (fail_count),
    .frames_due_o     (frames_due)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Run guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver stalls in random bursts, with stretches of steady draining.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      drain_steady <= !drain_steady;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!drain_steady && $urandom_range(0, 2) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Presents one byte and returns at the falling edge after its transaction.
  // Valid stays high when the next byte follows without a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    buffer_end <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  // Sends the queued buffer, flagging its last byte.
  task automatic send_buffer();
    int unsigned i;
    for (i = 0; i < buffer_q.size(); i++) begin
      send_byte(buffer_q[i], i == buffer_q.size() - 1);
    end
    buffer_q.delete();
  endtask

  // Holds the sender off until every framed result has been taken.
  task automatic drain_wait();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (frames_due != 0);
  endtask

  // Builds a buffer of mostly well-formed messages with random content. The
  // buffer is cut at a random length, so its tail may be an unfinished
  // message or span.
  task automatic build_random_buffer();
    int unsigned target;
    int unsigned roll;
    int unsigned n;
    logic [7:0]  status;
    target = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 40);
    while (buffer_q.size() < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        // Any status byte but a sysex open, with its data bytes.
        status = 8'($urandom_range(8'h80, 8'hFF));
        if (status == SYSEX_OPEN) begin
          status = SYSEX_CLOSE;
        end
        buffer_q.push_back(status);
        if ((status & 8'hF0) == PROGRAM_CHANGE || (status & 8'hF0) == CHANNEL_PRESSURE) begin
          n = 1;
        end else if ((status & 8'hF0) != SYSEX_OPEN) begin
          n = 2;
        end else if (status == SONG_POSITION) begin
          n = 2;
        end else if (status == TIME_CODE || status == SONG_SELECT) begin
          n = 1;
        end else begin
          n = 0;
        end
        repeat (n) begin
          buffer_q.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 127)));
        end
      end else if (roll < 75) begin
        // System exclusive span, sometimes nested, sometimes left open.
        buffer_q.push_back(SYSEX_OPEN);
        n = $urandom_range(0, 20);
        repeat (n) begin
          if ($urandom_range(0, 15) == 0) begin
            buffer_q.push_back(SYSEX_OPEN);
            buffer_q.push_back(8'($urandom_range(0, 255)));
            buffer_q.push_back(SYSEX_CLOSE);
          end else begin
            buffer_q.push_back(8'($urandom_range(0, 127)));
          end
        end
        if ($urandom_range(0, 7) != 0) begin
          buffer_q.push_back(SYSEX_CLOSE);
        end
      end else if (roll < 96) begin
        buffer_q.push_back(8'($urandom_range(TIMING_CLOCK, SYSTEM_RESET)));
      end else begin
        // Noise; a data byte here can abort the rest of the buffer.
        buffer_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (buffer_q.size() > target) begin
      void'(buffer_q.pop_back());
    end
  endtask

  initial begin
    int unsigned random_sent;
    random_sent = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes, every message length, a stray close, data bytes
    // with the top bit set, a nested span, a span flushed at the buffer end.
    buffer_q = '{NOTE_ON, 8'h00, 8'h7F, PROGRAM_CHANGE | 8'h05, 8'h40, TIMING_CLOCK,
                 SYSEX_CLOSE, TIME_CODE, 8'h12, SONG_POSITION, 8'h01, 8'h02, SYSTEM_RESET,
                 NOTE_OFF, SYSEX_OPEN, 8'hFF, SYSEX_OPEN, 8'h01, SYSEX_OPEN, 8'h02,
                 SYSEX_CLOSE, 8'h03, SYSEX_CLOSE, SYSEX_OPEN, 8'h55};
    send_buffer();
    // Message cut off by the buffer end, after and at its status byte.
    buffer_q = '{CONTROL_CHANGE, 8'h10};
    send_buffer();
    buffer_q = '{CHANNEL_PRESSURE};
    send_buffer();
    // Data byte in status position; the rest of the buffer is ignored.
    buffer_q = '{NOTE_ON, 8'h3C, 8'h00, 8'h55, NOTE_ON};
    send_buffer();
    drain_wait();

    // Depth saturation across two chunk boundaries, closed again by closes.
    sender_steady = 1'b1;
    repeat (300) buffer_q.push_back(SYSEX_OPEN);
    repeat (255) buffer_q.push_back(SYSEX_CLOSE);
    buffer_q.push_back(TIMING_CLOCK);
    send_buffer();
    sender_steady = 1'b0;
    drain_wait();

    // Random buffers, some of them sent without gaps.
    while (random_sent < RANDOM_BYTES) begin
      sender_steady = ($urandom_range(0, 4) == 0);
      build_random_buffer();
      random_sent += buffer_q.size();
      send_buffer();
    end
    sender_steady = 1'b0;

    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && frames_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
